// ----- sv/apool_pkg.sv -----
package apool_pkg;

	// Field and register widths.
	localparam int CFG_W     = 7;
	localparam int CFG_MAX   = 127;
	localparam int PIX_W     = 16;
	localparam int OIDX_W    = 6;
	localparam int CFG_IDX_W = 3;

	// Default plane limits for the top-level parameters.
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS = 3'd3;

	// Configuration values after reset.
	localparam logic [CFG_W-1:0] RST_IN_ROWS  = 7'd64;
	localparam logic [CFG_W-1:0] RST_IN_COLS  = 7'd64;
	localparam logic [CFG_W-1:0] RST_OUT_ROWS = 7'd1;
	localparam logic [CFG_W-1:0] RST_OUT_COLS = 7'd1;

	// Control states: geometry derivation, then the per-pixel sequence.
	typedef enum logic [2:0] {
		ST_CLAMP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SIZE,
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ----- sv/apool_if.sv -----
// Pixel stream channel.
interface apool_pix_if;
	logic                                valid;
	logic                                ready;
	logic signed [apool_pkg::PIX_W-1:0]  pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

// Pooled result channel.
interface apool_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [apool_pkg::PIX_W-1:0]  max_value;
	logic        [apool_pkg::OIDX_W-1:0] out_row;
	logic        [apool_pkg::OIDX_W-1:0] out_col;
	logic                                last_of_plane;

	modport source (output valid, output max_value, output out_row, output out_col,
		output last_of_plane, input ready);
	modport sink (input valid, input max_value, input out_row, input out_col,
		input last_of_plane, output ready);
endinterface

// Configuration write channel.
interface apool_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [apool_pkg::CFG_IDX_W-1:0]       index;
	logic [apool_pkg::CFG_W-1:0]           data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/apool_ram.sv -----
module apool_ram #(
	parameter int WIDTH = apool_pkg::PIX_W,
	parameter int DEPTH = apool_pkg::DEF_MAX_ROWS * apool_pkg::DEF_MAX_COLS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/apool_cell.sv -----
module apool_cell (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [apool_pkg::PIX_W-1:0] x,
	input  logic signed [apool_pkg::PIX_W-1:0] prev,
	output logic signed [apool_pkg::PIX_W-1:0] val
);

	logic signed [apool_pkg::PIX_W-1:0] val_q;

	// Cell k holds the maximum of the last k+1 words: the neighbor's old
	// maximum of k words, extended by the incoming word.
	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= (x > prev) ? x : prev;
		end
	end

	assign val = val_q;

endmodule

// ----- sv/apool_div.sv -----
module apool_div #(
	parameter int W = apool_pkg::CFG_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign ge      = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? (shifted - {1'b0, divisor}) : shifted;
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/adaptive_max_pool_2d.sv -----
// Channel  Dir  Payload                                        Word accepted when
// -------  ---  ---------------------------------------------  -------------------
// pix      in   pixel_value (s16, Q8.8)                        valid && ready
// res      out  max_value (s16), out_row, out_col, last_of_plane valid && ready
// cfg      in   index (3 bits), data (7 bits)                  valid && ready
//
// A pixel that closes no window is accepted, then written to the store.
// One that closes a window then reads size_r - 1 row maxima of its column
// (none when size_r is 1) through the registered read port, and then emits.
// After reset and after each write to a known register, the sizes are clamped, divided
// and the window size set before the first pixel is taken; the store needs no clearing.
// A waiting result does not stop the next pixel; only the next emit waits on it.
module adaptive_max_pool_2d #(
	parameter int MAX_ROWS = apool_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = apool_pkg::DEF_MAX_COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	apool_pix_if.sink        pix,
	apool_res_if.source      res,
	apool_cfg_if.sink        cfg
);

	localparam int CW       = apool_pkg::CFG_W;
	localparam int PW       = apool_pkg::PIX_W;
	localparam int OW       = apool_pkg::OIDX_W;
	localparam int ROWS_EFF = (MAX_ROWS < apool_pkg::CFG_MAX) ? MAX_ROWS : apool_pkg::CFG_MAX;
	localparam int COLS_EFF = (MAX_COLS < apool_pkg::CFG_MAX) ? MAX_COLS : apool_pkg::CFG_MAX;
	localparam int RPW      = (ROWS_EFF > 1) ? $clog2(ROWS_EFF) : 1;
	localparam int CPW      = (COLS_EFF > 1) ? $clog2(COLS_EFF) : 1;
	localparam int AW       = RPW + CPW;
	localparam logic [CW-1:0] ROWS_LIM = CW'(ROWS_EFF);
	localparam logic [CW-1:0] COLS_LIM = CW'(COLS_EFF);

	// Configuration registers.
	logic [CW-1:0] reg_in_rows_q, reg_in_cols_q, reg_out_rows_q, reg_out_cols_q;

	// Derived geometry.
	logic [CW-1:0] eff_in_r_q, eff_in_c_q, eff_out_r_q, eff_out_c_q;
	logic [CW-1:0] stride_r_q, stride_c_q, size_r_q, size_c_q;

	// Stream position and window tracking.
	logic [RPW-1:0] row_q;
	logic [CPW-1:0] col_q;
	logic [CW:0]    row_close_q, col_close_q, row_top_q;
	logic [CW-1:0]  k_r_q, k_c_q;

	// Pixel being processed.
	logic [RPW-1:0] cur_row_q;
	logic [CPW-1:0] cur_col_q;
	logic [OW-1:0]  snap_row_q, snap_col_q;
	logic           close_q, last_q;

	// Window scan.
	logic [RPW-1:0] scan_row_q;
	logic [CW-1:0]  rd_cnt_q;
	logic           rd_valid_s1, rd_last_s1;
	logic [PW-1:0]  best_q;

	// Result register.
	logic           res_valid_q;
	logic [PW-1:0]  res_max_q;
	logic [OW-1:0]  res_row_q, res_col_q;
	logic           res_last_q;

	apool_pkg::state_t state_q, state_d;

	logic cfg_hit, accept, ram_we, rd_issue, load_res;
	logic row_is_close, col_is_close, row_end, col_end;
	logic [CW-1:0] cl_in_r, cl_in_c, cl_out_r, cl_out_c;
	logic [CW-1:0] quo_r, quo_c, size_r_d, size_c_d;
	logic          done_r, done_c;
	logic [2*CW-1:0] prod_r, prod_c;
	logic [PW-1:0] ram_rdata;
	logic signed [PW-1:0] cell_val [COLS_EFF];
	logic [CPW-1:0] hsel;
	logic [PW-1:0] hmax;

	// Configuration writes; an unknown index is dropped.
	assign cfg.ready = 1'b1;
	assign cfg_hit = cfg.valid && cfg.ready &&
		(cfg.index == apool_pkg::REG_IN_ROWS || cfg.index == apool_pkg::REG_IN_COLS ||
		 cfg.index == apool_pkg::REG_OUT_ROWS || cfg.index == apool_pkg::REG_OUT_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_in_rows_q  <= apool_pkg::RST_IN_ROWS;
			reg_in_cols_q  <= apool_pkg::RST_IN_COLS;
			reg_out_rows_q <= apool_pkg::RST_OUT_ROWS;
			reg_out_cols_q <= apool_pkg::RST_OUT_COLS;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				apool_pkg::REG_IN_ROWS:  reg_in_rows_q  <= cfg.data;
				apool_pkg::REG_IN_COLS:  reg_in_cols_q  <= cfg.data;
				apool_pkg::REG_OUT_ROWS: reg_out_rows_q <= cfg.data;
				apool_pkg::REG_OUT_COLS: reg_out_cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Saturate sizes: zero to one, inputs to the plane limit, outputs to the input size.
	always_comb begin
		cl_in_r  = (reg_in_rows_q == '0) ? CW'(1) :
			((reg_in_rows_q > ROWS_LIM) ? ROWS_LIM : reg_in_rows_q);
		cl_in_c  = (reg_in_cols_q == '0) ? CW'(1) :
			((reg_in_cols_q > COLS_LIM) ? COLS_LIM : reg_in_cols_q);
		cl_out_r = (reg_out_rows_q == '0) ? CW'(1) :
			((reg_out_rows_q > cl_in_r) ? cl_in_r : reg_out_rows_q);
		cl_out_c = (reg_out_cols_q == '0) ? CW'(1) :
			((reg_out_cols_q > cl_in_c) ? cl_in_c : reg_out_cols_q);
	end

	// Stride is in / out, one quotient bit per cycle.
	apool_div #(.W(CW)) u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == apool_pkg::ST_DIV_GO),
		.dividend (eff_in_r_q),
		.divisor  (eff_out_r_q),
		.done     (done_r),
		.quotient (quo_r)
	);

	apool_div #(.W(CW)) u_div_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == apool_pkg::ST_DIV_GO),
		.dividend (eff_in_c_q),
		.divisor  (eff_out_c_q),
		.done     (done_c),
		.quotient (quo_c)
	);

	// Window size is in - (out - 1) * stride.
	assign prod_r   = (2*CW)'(eff_out_r_q - 1'b1) * (2*CW)'(stride_r_q);
	assign prod_c   = (2*CW)'(eff_out_c_q - 1'b1) * (2*CW)'(stride_c_q);
	assign size_r_d = CW'((2*CW)'(eff_in_r_q) - prod_r);
	assign size_c_d = CW'((2*CW)'(eff_in_c_q) - prod_c);

	// Where the incoming pixel sits relative to the next closing window.
	assign row_is_close = (CW+1)'(row_q) == row_close_q;
	assign col_is_close = (CW+1)'(col_q) == col_close_q;
	assign row_end      = CW'(row_q) == (eff_in_r_q - 1'b1);
	assign col_end      = CW'(col_q) == (eff_in_c_q - 1'b1);

	// Chain of cells: cell k holds the maximum of the last k+1 pixels.
	genvar gk;
	generate
		for (gk = 0; gk < COLS_EFF; gk++) begin : g_chain
			if (gk == 0) begin : g_head
				apool_cell u_cell (
					.clk  (clk),
					.en   (accept),
					.x    (pix.pixel_value),
					.prev (pix.pixel_value),
					.val  (cell_val[gk])
				);
			end else begin : g_body
				apool_cell u_cell (
					.clk  (clk),
					.en   (accept),
					.x    (pix.pixel_value),
					.prev (cell_val[gk-1]),
					.val  (cell_val[gk])
				);
			end
		end
	endgenerate

	// Row maximum over the window width, ending at the current pixel.
	assign hsel = CPW'(size_c_q - 1'b1);
	assign hmax = cell_val[hsel];

	// Store of row maxima, addressed by row and column.
	apool_ram #(.WIDTH(PW), .DEPTH(1 << AW)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({cur_row_q, cur_col_q}),
		.wdata (hmax),
		.raddr ({scan_row_q, cur_col_q}),
		.rdata (ram_rdata)
	);

	// Next state and control strobes.
	always_comb begin
		state_d   = state_q;
		accept    = 1'b0;
		ram_we    = 1'b0;
		rd_issue  = 1'b0;
		load_res  = 1'b0;
		pix.ready = 1'b0;
		case (state_q)
			apool_pkg::ST_CLAMP:    state_d = apool_pkg::ST_DIV_GO;
			apool_pkg::ST_DIV_GO:   state_d = apool_pkg::ST_DIV_WAIT;
			apool_pkg::ST_DIV_WAIT: begin
				if (done_r && done_c) begin
					state_d = apool_pkg::ST_SIZE;
				end
			end
			apool_pkg::ST_SIZE:     state_d = apool_pkg::ST_IDLE;
			apool_pkg::ST_IDLE: begin
				pix.ready = 1'b1;
				if (pix.valid) begin
					accept  = 1'b1;
					state_d = apool_pkg::ST_WRITE;
				end
			end
			apool_pkg::ST_WRITE: begin
				ram_we = 1'b1;
				if (!close_q) begin
					state_d = apool_pkg::ST_IDLE;
				end else if (rd_cnt_q == '0) begin
					state_d = apool_pkg::ST_EMIT;
				end else begin
					state_d = apool_pkg::ST_SCAN;
				end
			end
			apool_pkg::ST_SCAN: begin
				rd_issue = rd_cnt_q != '0;
				if (rd_valid_s1 && rd_last_s1) begin
					state_d = apool_pkg::ST_EMIT;
				end
			end
			apool_pkg::ST_EMIT: begin
				if (!res_valid_q || res.ready) begin
					load_res = 1'b1;
					state_d  = apool_pkg::ST_IDLE;
				end
			end
			default: state_d = apool_pkg::ST_CLAMP;
		endcase
		if (cfg_hit) begin
			state_d = apool_pkg::ST_CLAMP;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apool_pkg::ST_CLAMP;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			res_valid_q <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			row_close_q <= '0;
			col_close_q <= '0;
			row_top_q   <= '0;
			k_r_q       <= '0;
			k_c_q       <= '0;
			close_q     <= 1'b0;
			rd_cnt_q    <= '0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_issue;
			rd_last_s1  <= rd_issue && (rd_cnt_q == CW'(1));

			// Result register: loaded on emit, freed when taken.
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q - 1'b1;
			end

			// New geometry restarts the plane.
			if (state_q == apool_pkg::ST_SIZE) begin
				row_q       <= '0;
				col_q       <= '0;
				row_close_q <= (CW+1)'(size_r_d) - 1'b1;
				col_close_q <= (CW+1)'(size_c_d) - 1'b1;
				row_top_q   <= '0;
				k_r_q       <= '0;
				k_c_q       <= '0;
			end

			// Accepted pixel: note its window role, then step the raster position.
			if (accept) begin
				close_q  <= row_is_close && col_is_close;
				rd_cnt_q <= size_r_q - 1'b1;
				if (col_end) begin
					col_q       <= '0;
					col_close_q <= (CW+1)'(size_c_q) - 1'b1;
					k_c_q       <= '0;
					if (row_end) begin
						row_q       <= '0;
						row_close_q <= (CW+1)'(size_r_q) - 1'b1;
						row_top_q   <= '0;
						k_r_q       <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						if (row_is_close) begin
							row_close_q <= row_close_q + (CW+1)'(stride_r_q);
							row_top_q   <= row_top_q + (CW+1)'(stride_r_q);
							k_r_q       <= k_r_q + 1'b1;
						end
					end
				end else begin
					col_q <= col_q + 1'b1;
					if (col_is_close) begin
						col_close_q <= col_close_q + (CW+1)'(stride_c_q);
						k_c_q       <= k_c_q + 1'b1;
					end
				end
			end
		end
	end

	// Geometry, pixel snapshot, scan and result payload.
	always_ff @(posedge clk) begin
		if (state_q == apool_pkg::ST_CLAMP) begin
			eff_in_r_q  <= cl_in_r;
			eff_in_c_q  <= cl_in_c;
			eff_out_r_q <= cl_out_r;
			eff_out_c_q <= cl_out_c;
		end
		if (done_r && done_c) begin
			stride_r_q <= quo_r;
			stride_c_q <= quo_c;
		end
		if (state_q == apool_pkg::ST_SIZE) begin
			size_r_q <= size_r_d;
			size_c_q <= size_c_d;
		end
		if (accept) begin
			cur_row_q  <= row_q;
			cur_col_q  <= col_q;
			snap_row_q <= k_r_q[OW-1:0];
			snap_col_q <= k_c_q[OW-1:0];
			last_q     <= row_end && col_end;
			scan_row_q <= row_top_q[RPW-1:0];
		end
		if (rd_issue) begin
			scan_row_q <= scan_row_q + 1'b1;
		end
		if (ram_we) begin
			best_q <= hmax;
		end else if (rd_valid_s1 && ($signed(ram_rdata) > $signed(best_q))) begin
			best_q <= ram_rdata;
		end
		if (load_res) begin
			res_max_q  <= best_q;
			res_row_q  <= snap_row_q;
			res_col_q  <= snap_col_q;
			res_last_q <= last_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.max_value     = res_max_q;
	assign res.out_row       = res_row_q;
	assign res.out_col       = res_col_q;
	assign res.last_of_plane = res_last_q;

	// The scan only reads rows above the pixel just written.
	a_scan_above: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> scan_row_q < cur_row_q)
		else $error("window scan reads at or below the current row");

	// A register write holds off pixels while the geometry is rederived.
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !pix.ready)
		else $error("pixel taken right after a configuration write");

	// A new result appears only out of the emit step.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == apool_pkg::ST_EMIT))
		else $error("result raised outside the emit step");

	// Every scan read has been folded in before the result is formed.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == apool_pkg::ST_EMIT |-> !rd_valid_s1)
		else $error("read data still in flight at emit");

endmodule

// ----- dv/tb_top.sv -----
// One pooled window as it leaves the block.
typedef struct {
	logic signed [apool_pkg::PIX_W-1:0]  max_value;
	logic        [apool_pkg::OIDX_W-1:0] out_row;
	logic        [apool_pkg::OIDX_W-1:0] out_col;
	logic                                last_of_plane;
} window_result_t;

// Tracks the pooling geometry and the current plane, and predicts each window maximum.
class pooled_max_scoreboard;
	localparam int PLANE_R = apool_pkg::DEF_MAX_ROWS;
	localparam int PLANE_C = apool_pkg::DEF_MAX_COLS;
	localparam int PW      = apool_pkg::PIX_W;
	localparam int CW      = apool_pkg::CFG_W;
	localparam int IW      = apool_pkg::CFG_IDX_W;
	localparam int OW      = apool_pkg::OIDX_W;

	logic signed [PW-1:0] plane_mem [PLANE_R*PLANE_C];
	logic        [CW-1:0] regs [1 << IW];
	int unsigned in_rows_eff, in_cols_eff, out_rows_eff, out_cols_eff;
	int unsigned stride_r, stride_c, win_r, win_c;
	int unsigned row_pos, col_pos;
	window_result_t pending_windows [$];
	int unsigned mismatches;

	function new();
		regs[apool_pkg::REG_IN_ROWS]  = apool_pkg::RST_IN_ROWS;
		regs[apool_pkg::REG_IN_COLS]  = apool_pkg::RST_IN_COLS;
		regs[apool_pkg::REG_OUT_ROWS] = apool_pkg::RST_OUT_ROWS;
		regs[apool_pkg::REG_OUT_COLS] = apool_pkg::RST_OUT_COLS;
		mismatches = 0;
		regeometry();
	endfunction

	function int unsigned clamp_size(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Sizes saturate, then stride and window size follow; the plane restarts.
	function void regeometry();
		in_rows_eff  = clamp_size(regs[apool_pkg::REG_IN_ROWS], PLANE_R);
		in_cols_eff  = clamp_size(regs[apool_pkg::REG_IN_COLS], PLANE_C);
		out_rows_eff = clamp_size(regs[apool_pkg::REG_OUT_ROWS], in_rows_eff);
		out_cols_eff = clamp_size(regs[apool_pkg::REG_OUT_COLS], in_cols_eff);
		stride_r = in_rows_eff / out_rows_eff;
		stride_c = in_cols_eff / out_cols_eff;
		win_r = in_rows_eff - (out_rows_eff - 1) * stride_r;
		win_c = in_cols_eff - (out_cols_eff - 1) * stride_c;
		row_pos = 0;
		col_pos = 0;
	endfunction

	// A write to an index outside the register file leaves everything as it was.
	function void write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
		case (idx)
			apool_pkg::REG_IN_ROWS, apool_pkg::REG_IN_COLS,
			apool_pkg::REG_OUT_ROWS, apool_pkg::REG_OUT_COLS: begin
				regs[idx] = data;
				regeometry();
			end
			default: ;
		endcase
	endfunction

	// Store the pixel; if it is the bottom-right corner of a window, predict that window.
	function void take_pixel(logic signed [PW-1:0] v);
		int unsigned top, left, i, j;
		logic signed [PW-1:0] best;
		window_result_t w;
		plane_mem[row_pos*PLANE_C + col_pos] = v;
		if (row_pos + 1 >= win_r && col_pos + 1 >= win_c) begin
			top  = row_pos + 1 - win_r;
			left = col_pos + 1 - win_c;
			if (top % stride_r == 0 && left % stride_c == 0) begin
				best = plane_mem[top*PLANE_C + left];
				for (i = top; i <= row_pos; i++) begin
					for (j = left; j <= col_pos; j++) begin
						if (plane_mem[i*PLANE_C + j] > best)
							best = plane_mem[i*PLANE_C + j];
					end
				end
				w.max_value     = best;
				w.out_row       = OW'(top / stride_r);
				w.out_col       = OW'(left / stride_c);
				w.last_of_plane = (row_pos + 1 == in_rows_eff && col_pos + 1 == in_cols_eff);
				pending_windows.insert(pending_windows.size(), w);
			end
		end
		// Raster advance, wrapping into the next plane.
		col_pos++;
		if (col_pos >= in_cols_eff) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= in_rows_eff) row_pos = 0;
		end
	endfunction

	function void check_window(window_result_t got);
		window_result_t exp;
		if (pending_windows.size() == 0) begin
			$error("window with none pending: max_value %0d, out_row %0d, out_col %0d",
				got.max_value, got.out_row, got.out_col);
			mismatches++;
			return;
		end
		exp = pending_windows.pop_front();
		if (got.max_value !== exp.max_value) begin
			$error("max_value: expected %0d, got %0d", exp.max_value, got.max_value);
			mismatches++;
		end
		if (got.out_row !== exp.out_row) begin
			$error("out_row: expected %0d, got %0d", exp.out_row, got.out_row);
			mismatches++;
		end
		if (got.out_col !== exp.out_col) begin
			$error("out_col: expected %0d, got %0d", exp.out_col, got.out_col);
			mismatches++;
		end
		if (got.last_of_plane !== exp.last_of_plane) begin
			$error("last_of_plane: expected %0d, got %0d", exp.last_of_plane, got.last_of_plane);
			mismatches++;
		end
	endfunction

	function int unsigned pending();
		return pending_windows.size();
	endfunction
endclass

module tb_top;
	localparam int          PW         = apool_pkg::PIX_W;
	localparam int          CW         = apool_pkg::CFG_W;
	localparam int          IW         = apool_pkg::CFG_IDX_W;
	localparam int          N_RANDOM   = 1900;
	localparam int          SETTLE     = apool_pkg::DEF_MAX_ROWS + 16;
	localparam int          LONG_HOLD  = 300;
	localparam longint      LIMIT_TIME = 10_000_000;
	localparam logic [IW-1:0] REG_OUTSIDE = apool_pkg::REG_OUT_COLS + 3'd1;
	localparam logic [IW-1:0] REG_TOP_IDX = {IW{1'b1}};

	logic clk = 1'b0;
	logic arst_n;

	apool_pix_if pix ();
	apool_res_if res ();
	apool_cfg_if cfg ();

	pooled_max_scoreboard sb = new();

	// Idle rates shared by the driving processes, in percent per word.
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	bit          hold_request = 1'b0;

	adaptive_max_pool_2d uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// Watch every handshake; results are checked before the same edge's pixel is noted.
	always @(posedge clk) begin : watch
		window_result_t got;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got.max_value     = res.max_value;
				got.out_row       = res.out_row;
				got.out_col       = res.out_col;
				got.last_of_plane = res.last_of_plane;
				sb.check_window(got);
			end
			if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
			if (pix.valid && pix.ready) sb.take_pixel(pix.pixel_value);
		end
	end

	// Result receiver: short random stalls, and one long hold on request.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
				stall_left = $urandom_range(0, 3);
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Offer one pixel word, possibly after a short gap, and wait for its acceptance.
	task automatic send_pixel(input logic signed [PW-1:0] v);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.pixel_value <= v;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
	endtask

	// One register word, then valid is dropped, so back-to-back writes never collide.
	task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering pixels, collect every pending window, then let a window scan finish.
	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [PW-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return PW'($urandom_range(0, 7) - 4);
			default: return PW'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// Large plane side: mostly 40 to 64, sometimes 65 to 127, beyond the plane limit.
	function automatic int unsigned big_size();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(65, 127) : $urandom_range(40, 64);
	endfunction

	function automatic int unsigned pick_out_size(int unsigned in_size);
		int unsigned eff;
		eff = (in_size < 1) ? 1 :
			((in_size > apool_pkg::DEF_MAX_ROWS) ? apool_pkg::DEF_MAX_ROWS : in_size);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(eff, 127);
			default: return $urandom_range(1, eff);
		endcase
	endfunction

	initial begin : stimulus
		logic signed [PW-1:0] edge_vals [6];
		logic        [CW-1:0] vals [1 << IW];
		int unsigned order [4];
		int unsigned sent, count, plane, k, swap_at, tmp, sel, ir, ic;
		bit quiet;

		pix.valid       <= 1'b0;
		pix.pixel_value <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= '0;
		cfg.data        <= '0;
		arst_n          <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry is one 64x64 window, so a few pixels close nothing.
		send_pixel(16'sh7FFF);
		send_pixel(16'sh8000);
		send_pixel(16'sh0000);
		wait_idle();

		// Zero input height, zero output height and oversized output width: a 1x3 plane
		// with one-pixel windows, so every pixel is a result.
		write_reg(apool_pkg::REG_IN_ROWS, 7'd0);
		write_reg(apool_pkg::REG_IN_COLS, 7'd3);
		write_reg(apool_pkg::REG_OUT_ROWS, 7'd0);
		write_reg(apool_pkg::REG_OUT_COLS, 7'd127);
		edge_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0100, 16'sh8001};
		foreach (edge_vals[e]) send_pixel(edge_vals[e]);

		// A write to an unused index must not restart the plane.
		send_pixel(16'sh0123);
		wait_idle();
		write_reg(REG_OUTSIDE, 7'd2);
		send_pixel(16'sh0456);
		send_pixel(16'shFEDC);
		wait_idle();

		// Oversized input height saturates to 64 rows of two; pairs pooled per row.
		write_reg(apool_pkg::REG_IN_ROWS, 7'd127);
		write_reg(apool_pkg::REG_IN_COLS, 7'd2);
		write_reg(apool_pkg::REG_OUT_ROWS, 7'd64);
		write_reg(apool_pkg::REG_OUT_COLS, 7'd1);
		send_pixel(16'sh8000);
		send_pixel(16'sh8000);
		send_pixel(16'sh7FFF);
		send_pixel(16'sh8000);
		send_pixel(16'shFFFF);
		send_pixel(16'sh0001);
		wait_idle();

		// Overlapping 2x2 windows on a 3x3 plane; rewriting a register restarts the plane.
		write_reg(apool_pkg::REG_IN_ROWS, 7'd3);
		write_reg(apool_pkg::REG_IN_COLS, 7'd3);
		write_reg(apool_pkg::REG_OUT_ROWS, 7'd2);
		write_reg(apool_pkg::REG_OUT_COLS, 7'd2);
		repeat (5) send_pixel(rand_pixel());
		wait_idle();
		write_reg(apool_pkg::REG_IN_ROWS, 7'd3);
		repeat (4) send_pixel(rand_pixel());
		wait_idle();

		// Every pixel closes a window while the receiver holds off, so the block backs up.
		write_reg(apool_pkg::REG_IN_ROWS, 7'd8);
		write_reg(apool_pkg::REG_IN_COLS, 7'd8);
		write_reg(apool_pkg::REG_OUT_ROWS, 7'd8);
		write_reg(apool_pkg::REG_OUT_COLS, 7'd8);
		hold_request = 1'b1;
		sent = 0;
		repeat (64) begin
			send_pixel(rand_pixel());
			sent++;
		end

		// Random phases: new geometry, then whole planes and sometimes a partial one.
		quiet = 1'b0;
		while (sent < N_RANDOM) begin
			wait_idle();
			if (sent >= N_RANDOM * 85 / 100) quiet = 1'b1;
			src_idle_pct = quiet ? 0 : pick_idle_pct();
			snk_idle_pct = quiet ? 0 : pick_idle_pct();

			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				ir = $urandom_range(1, 10);
				ic = $urandom_range(1, 10);
			end else if (sel < 9) begin
				if ($urandom_range(0, 1)) begin
					ir = big_size();
					ic = $urandom_range(1, 3);
				end else begin
					ir = $urandom_range(1, 3);
					ic = big_size();
				end
			end else begin
				ir = big_size();
				ic = big_size();
			end
			if ($urandom_range(0, 15) == 0) ir = 0;
			if ($urandom_range(0, 15) == 0) ic = 0;
			vals[apool_pkg::REG_IN_ROWS] = CW'(ir);
			vals[apool_pkg::REG_IN_COLS] = CW'(ic);
			if (sel == 9) begin
				// Both sides large: keep windows small so partial planes still emit.
				vals[apool_pkg::REG_OUT_ROWS] = CW'((ir > 64 ? 64 : ir) - $urandom_range(0, 2));
				vals[apool_pkg::REG_OUT_COLS] = CW'((ic > 64 ? 64 : ic) - $urandom_range(0, 2));
			end else begin
				vals[apool_pkg::REG_OUT_ROWS] = CW'(pick_out_size(ir));
				vals[apool_pkg::REG_OUT_COLS] = CW'(pick_out_size(ic));
			end

			// Program the registers in random order, sometimes skipping some.
			for (k = 0; k < 4; k++) order[k] = k;
			for (k = 3; k > 0; k--) begin
				swap_at = $urandom_range(0, k);
				tmp = order[k];
				order[k] = order[swap_at];
				order[swap_at] = tmp;
			end
			for (k = 0; k < 4; k++) begin
				if (k == 0 || $urandom_range(0, 4) != 0)
					write_reg(IW'(order[k]), vals[order[k]]);
			end
			if ($urandom_range(0, 5) == 0)
				write_reg(IW'($urandom_range(REG_OUTSIDE, REG_TOP_IDX)), CW'($urandom));

			plane = sb.in_rows_eff * sb.in_cols_eff;
			if (plane <= 256) begin
				count = plane * $urandom_range(1, 3);
				if ($urandom_range(0, 2) == 0) count += $urandom_range(0, plane - 1);
			end else begin
				count = $urandom_range(40, 250);
			end
			// Keep the total close to the planned number of pixels.
			if (count > N_RANDOM - sent) count = N_RANDOM - sent;
			repeat (count) begin
				send_pixel(rand_pixel());
				sent++;
			end
		end

		wait_idle();
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Run limit.
	initial begin : watchdog
		#LIMIT_TIME;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
sv/apool_pkg.sv
sv/apool_if.sv
sv/apool_ram.sv
sv/apool_cell.sv
sv/apool_div.sv
sv/adaptive_max_pool_2d.sv
dv/tb_top.sv
